[src/icsp_pkg.sv]
// Shared types, constants and the command segment table for the ICSP programming master.
// Used by icsp_seq, icsp_obuf and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package icsp_pkg;

    // Command kinds carried in the input tuser field.
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_SEND      = 3'd1;
    localparam logic [2:0] KIND_READ      = 3'd2;
    localparam logic [2:0] KIND_CLOCKS    = 3'd3;
    localparam logic [2:0] KIND_READ14    = 3'd4;
    localparam logic [2:0] KIND_READBYTE  = 3'd5;
    localparam logic [2:0] KIND_DS_SEND24 = 3'd6;
    localparam logic [2:0] KIND_DS_READ16 = 3'd7;

    // Count saturation limits and the marker for a count taken from the command.
    localparam logic [7:0] MAX_SEND_BITS = 8'd24;
    localparam logic [7:0] MAX_READ_BITS = 8'd16;
    localparam logic [7:0] CNT_CMD       = 8'hFF;

    // Widths of the sequencer state.
    localparam int PHASE_W = 5;
    localparam int RXPOS_W = 5;

    // Segment types of a command sequence.
    typedef enum logic [2:0] {
        SEG_END      = 3'd0,
        SEG_SEND     = 3'd1,
        SEG_READ     = 3'd2,
        SEG_CLK      = 3'd3,
        SEG_ONE      = 3'd4,
        SEG_WAIT_IN  = 3'd5,
        SEG_WAIT_OUT = 3'd6
    } seg_type_t;

    typedef struct packed {
        seg_type_t  typ;
        logic [7:0] cnt;
    } seg_entry_t;

    // One result of the sequencer, handed to the output stage.
    typedef struct packed {
        logic        rejected;
        logic [15:0] read_data;
        logic        read_valid;
        logic        busy_res;
        logic        data_drive;
        logic        data_pin_out;
        logic        clock_pin;
    } icsp_res_t;

    // Segment list of each command kind; an index past the list reads as the end.
    function automatic seg_entry_t seg_lookup(input logic [2:0] kind, input logic [3:0] seg);
        seg_entry_t e;
        e.typ = SEG_END;
        e.cnt = 8'd0;
        unique case (kind)
            KIND_SEND:
            begin
                unique case (seg)
                    4'd0:    e = '{SEG_SEND, CNT_CMD};
                    4'd1:    e = '{SEG_WAIT_OUT, 8'd1};
                    default: e = '{SEG_END, 8'd0};
                endcase
            end
            KIND_READ:
            begin
                unique case (seg)
                    4'd0:    e = '{SEG_READ, CNT_CMD};
                    default: e = '{SEG_END, 8'd0};
                endcase
            end
            KIND_CLOCKS:
            begin
                unique case (seg)
                    4'd0:    e = '{SEG_CLK, CNT_CMD};
                    default: e = '{SEG_END, 8'd0};
                endcase
            end
            KIND_READ14:
            begin
                unique case (seg)
                    4'd0:    e = '{SEG_WAIT_IN, 8'd1};
                    4'd1:    e = '{SEG_CLK, 8'd1};
                    4'd2:    e = '{SEG_READ, 8'd14};
                    4'd3:    e = '{SEG_CLK, 8'd1};
                    4'd4:    e = '{SEG_WAIT_OUT, 8'd1};
                    default: e = '{SEG_END, 8'd0};
                endcase
            end
            KIND_READBYTE:
            begin
                unique case (seg)
                    4'd0:    e = '{SEG_CLK, 8'd8};
                    4'd1:    e = '{SEG_WAIT_IN, 8'd1};
                    4'd2:    e = '{SEG_READ, 8'd8};
                    4'd3:    e = '{SEG_WAIT_OUT, 8'd1};
                    default: e = '{SEG_END, 8'd0};
                endcase
            end
            KIND_DS_SEND24:
            begin
                unique case (seg)
                    4'd0:    e = '{SEG_CLK, 8'd4};
                    4'd1:    e = '{SEG_SEND, 8'd8};
                    4'd2:    e = '{SEG_WAIT_OUT, 8'd1};
                    4'd3:    e = '{SEG_SEND, 8'd8};
                    4'd4:    e = '{SEG_WAIT_OUT, 8'd1};
                    4'd5:    e = '{SEG_SEND, 8'd8};
                    4'd6:    e = '{SEG_WAIT_OUT, 8'd1};
                    default: e = '{SEG_END, 8'd0};
                endcase
            end
            KIND_DS_READ16:
            begin
                unique case (seg)
                    4'd0:    e = '{SEG_ONE, 8'd1};
                    4'd1:    e = '{SEG_CLK, 8'd11};
                    4'd2:    e = '{SEG_WAIT_IN, 8'd1};
                    4'd3:    e = '{SEG_READ, 8'd16};
                    default: e = '{SEG_END, 8'd0};
                endcase
            end
            default: e = '{SEG_END, 8'd0};
        endcase
        return e;
    endfunction

    // Count of a segment, with the command count substituted where the table asks.
    function automatic logic [7:0] seg_count(input seg_entry_t e, input logic [7:0] cmd_count);
        return (e.cnt == CNT_CMD) ? cmd_count : e.cnt;
    endfunction

    // Segments that toggle the clock line.
    function automatic logic is_pulse(input seg_type_t t);
        return (t == SEG_SEND) || (t == SEG_READ) || (t == SEG_CLK) || (t == SEG_ONE);
    endfunction

endpackage

`default_nettype wire

[src/icsp_seq.sv]
// Pin sequencer of the ICSP master: holds the sequence state and computes one tick per transaction.
// Depends on icsp_pkg for the segment table and the result type.
`timescale 1ns / 1ps
`default_nettype none

module icsp_seq
    import icsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        step,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  bit_count,
    input  wire logic [23:0] payload,
    input  wire logic        data_pin_in,
    output icsp_res_t        res
);

    logic [7:0]         hpd_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         dly_reg, dly_next;
    logic [7:0]         bits_reg, bits_next;
    logic [23:0]        send_reg, send_next;
    logic [15:0]        recv_reg, recv_next;
    logic               clk_pin_reg, clk_pin_next;
    logic               dat_pin_reg, dat_pin_next;
    logic               drv_pin_reg, drv_pin_next;
    logic [2:0]         kind_reg, kind_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [RXPOS_W-1:0] rxpos_reg, rxpos_next;
    logic               done_read;
    logic               rej;

    // One tick of the sequencer: advance a running sequence or start a new one.
    always_comb
    begin : step_logic
        logic [3:0]  seg_start;
        logic [3:0]  seg_b;
        logic [3:0]  ent_seg;
        logic [2:0]  cur_seg;
        logic        cur_half;
        logic [PHASE_W-1:0] code;
        seg_entry_t  ent_cur;
        seg_type_t   cur_type;
        seg_entry_t  ent_a;
        seg_entry_t  ent_b;
        seg_entry_t  ent_sel;
        logic [7:0]  bits_dec;
        logic        do_enter;
        logic        do_start;
        logic        do_finish;
        logic        ent_found;
        logic        st_half;
        seg_type_t   st_type;

        phase_next   = phase_reg;
        dly_next     = dly_reg;
        bits_next    = bits_reg;
        send_next    = send_reg;
        recv_next    = recv_reg;
        clk_pin_next = clk_pin_reg;
        dat_pin_next = dat_pin_reg;
        drv_pin_next = drv_pin_reg;
        kind_next    = kind_reg;
        cnt_next     = cnt_reg;
        rxpos_next   = rxpos_reg;
        done_read    = 1'b0;
        rej          = 1'b0;
        seg_start    = 4'd0;
        seg_b        = 4'd0;
        ent_seg      = 4'd0;
        code         = phase_reg - PHASE_W'(1);
        cur_seg      = code[3:1];
        cur_half     = code[0];
        ent_cur      = seg_lookup(kind_reg, {1'b0, cur_seg});
        cur_type     = ent_cur.typ;
        ent_a        = '{SEG_END, 8'd0};
        ent_b        = '{SEG_END, 8'd0};
        ent_sel      = '{SEG_END, 8'd0};
        bits_dec     = (bits_reg != 8'd0) ? (bits_reg - 8'd1) : 8'd0;
        do_enter     = 1'b0;
        do_start     = 1'b0;
        do_finish    = 1'b0;
        ent_found    = 1'b0;
        st_half      = 1'b0;
        st_type      = SEG_END;

        // Decide what this tick does.
        if (phase_reg != '0)
        begin
            rej = (kind != KIND_TICK);
            if (dly_reg != 8'd0)
            begin
                dly_next = dly_reg - 8'd1;
            end
            else if (is_pulse(cur_type) && !cur_half)
            begin
                phase_next = phase_reg + PHASE_W'(1);
                do_start   = 1'b1;
                st_type    = cur_type;
                st_half    = 1'b1;
            end
            else
            begin
                if (is_pulse(cur_type))
                begin
                    bits_next = bits_dec;
                end
                if (is_pulse(cur_type) && (bits_dec != 8'd0))
                begin
                    phase_next = phase_reg - PHASE_W'(1);
                    do_start   = 1'b1;
                    st_type    = cur_type;
                    st_half    = 1'b0;
                end
                else
                begin
                    do_enter  = 1'b1;
                    seg_start = {1'b0, cur_seg} + 4'd1;
                end
            end
        end
        else if (kind != KIND_TICK)
        begin
            kind_next = kind;
            if (kind == KIND_SEND)
            begin
                cnt_next = (bit_count > MAX_SEND_BITS) ? MAX_SEND_BITS : bit_count;
            end
            else if (kind == KIND_READ)
            begin
                cnt_next = (bit_count > MAX_READ_BITS) ? MAX_READ_BITS : bit_count;
            end
            else
            begin
                cnt_next = bit_count;
            end
            send_next  = payload;
            recv_next  = '0;
            rxpos_next = '0;
            do_enter   = 1'b1;
            seg_start  = 4'd0;
        end

        // Enter the next segment with a nonzero count. No segment list holds two
        // command-counted segments in a row, so at most one segment is skipped.
        if (do_enter)
        begin
            ent_a = seg_lookup(kind_next, seg_start);
            seg_b = seg_start + 4'd1;
            ent_b = seg_lookup(kind_next, seg_b);
            if (ent_a.typ == SEG_END)
            begin
                ent_found = 1'b0;
            end
            else if (seg_count(ent_a, cnt_next) != 8'd0)
            begin
                ent_found = 1'b1;
                ent_sel   = ent_a;
                ent_seg   = seg_start;
            end
            else
            begin
                ent_found = (ent_b.typ != SEG_END) && (seg_count(ent_b, cnt_next) != 8'd0);
                ent_sel   = ent_b;
                ent_seg   = seg_b;
            end
            if (ent_found)
            begin
                bits_next  = seg_count(ent_sel, cnt_next);
                phase_next = {1'b0, ent_seg[2:0], 1'b1};
                do_start   = 1'b1;
                st_type    = ent_sel.typ;
                st_half    = 1'b0;
            end
            else
            begin
                do_finish = 1'b1;
            end
        end

        // Set the pins for the phase that starts.
        if (do_start)
        begin
            dly_next = hpd_reg;
            unique case (st_type)
                SEG_WAIT_IN:
                begin
                    clk_pin_next = 1'b0;
                    drv_pin_next = 1'b0;
                end
                SEG_WAIT_OUT:
                begin
                    clk_pin_next = 1'b0;
                    drv_pin_next = 1'b1;
                end
                default:
                begin
                    if (!st_half)
                    begin
                        clk_pin_next = 1'b1;
                        if (st_type == SEG_SEND)
                        begin
                            dat_pin_next = send_next[0];
                        end
                        else if (st_type == SEG_ONE)
                        begin
                            dat_pin_next = 1'b1;
                        end
                        else if (st_type == SEG_CLK)
                        begin
                            dat_pin_next = 1'b0;
                        end
                    end
                    else
                    begin
                        clk_pin_next = 1'b0;
                        if (st_type == SEG_SEND)
                        begin
                            send_next = send_next >> 1;
                        end
                        else if (st_type == SEG_READ)
                        begin
                            // Sample the data line after the falling clock edge.
                            if (rxpos_next < RXPOS_W'(MAX_READ_BITS))
                            begin
                                if (data_pin_in)
                                begin
                                    recv_next[rxpos_next[3:0]] = 1'b1;
                                end
                                rxpos_next = rxpos_next + RXPOS_W'(1);
                            end
                        end
                        else
                        begin
                            dat_pin_next = 1'b0;
                        end
                    end
                end
            endcase
        end

        // End of a sequence: pins back to the idle levels.
        if (do_finish)
        begin
            phase_next   = '0;
            clk_pin_next = 1'b0;
            dat_pin_next = 1'b0;
            drv_pin_next = 1'b1;
            done_read    = (kind_next == KIND_READ) || (kind_next == KIND_READ14) ||
                           (kind_next == KIND_READBYTE) || (kind_next == KIND_DS_READ16);
        end
    end

    // Result of this tick.
    always_comb
    begin
        res.clock_pin    = clk_pin_next;
        res.data_pin_out = dat_pin_next;
        res.data_drive   = drv_pin_next;
        res.busy_res     = (phase_next != '0);
        res.read_valid   = done_read;
        res.read_data    = done_read ? recv_next : 16'd0;
        res.rejected     = rej;
    end

    // Sequencer state advances once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            dly_reg     <= '0;
            bits_reg    <= '0;
            send_reg    <= '0;
            recv_reg    <= '0;
            clk_pin_reg <= 1'b0;
            dat_pin_reg <= 1'b0;
            drv_pin_reg <= 1'b1;
            kind_reg    <= KIND_TICK;
            cnt_reg     <= '0;
            rxpos_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            dly_reg     <= dly_next;
            bits_reg    <= bits_next;
            send_reg    <= send_next;
            recv_reg    <= recv_next;
            clk_pin_reg <= clk_pin_next;
            dat_pin_reg <= dat_pin_next;
            drv_pin_reg <= drv_pin_next;
            kind_reg    <= kind_next;
            cnt_reg     <= cnt_next;
            rxpos_reg   <= rxpos_next;
        end
    end

    // Half-period delay register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpd_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            hpd_reg <= cfg_wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == '0) |-> (drv_pin_reg && !clk_pin_reg && !dat_pin_reg))
        else $error("idle sequencer does not hold the idle pin levels");

    a_rxpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        rxpos_reg <= RXPOS_W'(MAX_READ_BITS))
        else $error("read bit position ran past the word");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg != '0) && (kind != KIND_TICK)) |-> res.rejected)
        else $error("command during a sequence was not rejected");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.read_valid) |=> (phase_reg == '0))
        else $error("read finished but the sequence is still running");
`endif

endmodule

`default_nettype wire

[src/icsp_obuf.sv]
// Output register of the ICSP master: holds one result until the downstream side takes it.
// Depends on icsp_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module icsp_obuf
    import icsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire icsp_res_t in_res,
    output logic           out_valid,
    input  wire logic      out_ready,
    output icsp_res_t      out_res
);

    logic      valid_reg;
    icsp_res_t res_reg;

    // A new result may enter while the held one leaves in the same cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= in_res;
        end
    end

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (out_valid && (out_res == $past(in_res))))
        else $error("accepted result not presented on the next cycle");
`endif

endmodule

`default_nettype wire

[src/icsp_serial_programming_master_top.sv]
// A result appears on the master side in the cycle after its transaction is accepted.
// One transaction per cycle while the master side takes the results; each transaction is one
// tick of the pin sequencer, so a clock phase spans half_period_delay + 1 transactions.
// Reset (rst_n low, asynchronous): sequencer idle, clock low, data low and driven,
// half_period_delay zero, output register empty.
// Depends on icsp_pkg, icsp_seq and icsp_obuf.
`timescale 1ns / 1ps
`default_nettype none

module icsp_serial_programming_master_top
    import icsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // bit_count[7:0], payload[31:8], data_pin_in[32], zero
    input  wire logic [2:0]  s_tuser,   // kind[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // clock_pin[0], data_pin_out[1], data_drive[2],
                                        // busy_res[3], read_valid[4], read_data[20:5],
                                        // rejected[21], zero
);

    logic      step;
    icsp_res_t seq_res;
    icsp_res_t out_res;

    assign step = s_tvalid && s_tready;

    // Pin sequencer, one tick per accepted transaction.
    icsp_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .kind        (s_tuser),
        .bit_count   (s_tdata[7:0]),
        .payload     (s_tdata[31:8]),
        .data_pin_in (s_tdata[32]),
        .res         (seq_res)
    );

    // Result register toward the master side.
    icsp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (seq_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result fields, lowest first.
    assign m_tdata = {2'b00, out_res.rejected, out_res.read_data, out_res.read_valid,
                      out_res.busy_res, out_res.data_drive, out_res.data_pin_out,
                      out_res.clock_pin};

endmodule

`default_nettype wire
